// ===== rtl/domain_name_validator_core_macros.svh =====
// Assertion macros for the domain name validator.
// Included by the top level; no other dependencies.
`ifndef DOMAIN_NAME_VALIDATOR_CORE_MACROS_SVH
`define DOMAIN_NAME_VALIDATOR_CORE_MACROS_SVH

`ifndef SYNTH
// Checked property, masked while reset is low.
`define DNV_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Checked property, also during reset.
`define DNV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DNV_ASSERT(label, clk, rstn, prop)
`define DNV_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/dnv_pkg.sv =====
// Shared types and constants for the domain name validator.
// No dependencies.
package dnv_pkg;

    localparam int unsigned NAME_W  = 9;
    localparam int unsigned LABEL_W = 7;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned CFG_W   = 9;

    localparam logic [NAME_W-1:0]  NAME_LIMIT_RST  = 9'd255;
    localparam logic [LABEL_W-1:0] LABEL_LIMIT_RST = 7'd63;

    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;

    // Configuration register indexes
    typedef enum logic {
        CFG_MAX_NAME  = 1'b0,
        CFG_MAX_LABEL = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CHAR      = 3'd1,
        ERR_EDGE      = 3'd2,
        ERR_NAME_LEN  = 3'd3,
        ERR_LABEL_LEN = 3'd4
    } err_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } item_t;

    typedef struct packed {
        logic valid_res;
        err_t fault_code;
    } result_t;

endpackage

// ===== rtl/dnv_in_stage.sv =====
// Input register for one character item.
// Depends on dnv_pkg.
module dnv_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dnv_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output dnv_pkg::item_t item
);
    import dnv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ===== rtl/dnv_scan.sv =====
// Per-name scan state: counters, label flags and first error.
// Depends on dnv_pkg. Result is combinational from the current item.
module dnv_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  dnv_pkg::item_t               item,
    input  logic [dnv_pkg::NAME_W-1:0]   max_name,
    input  logic [dnv_pkg::LABEL_W-1:0]  max_label,
    output dnv_pkg::result_t             result
);
    import dnv_pkg::*;

    typedef struct packed {
        logic [LABEL_W-1:0] count;
        logic               first;
        logic               prev_hyphen;
        logic               has_digit;
        logic               start_bad;
        logic               bad_char;
        logic               over;
    } label_t;

    localparam label_t LABEL_CLR = '{count: '0, first: 1'b1, default: 1'b0};

    function automatic err_t close_code(input label_t l, input logic final_lbl);
        err_t e;
        e = ERR_NONE;
        if (l.first) begin
            e = final_lbl ? ERR_CHAR : ERR_EDGE;
        end else if (l.over) begin
            e = ERR_LABEL_LEN;
        end else if (l.start_bad || l.prev_hyphen) begin
            e = ERR_EDGE;
        end else if (l.bad_char || (final_lbl && l.has_digit)) begin
            e = ERR_CHAR;
        end
        return e;
    endfunction

    logic [NAME_W-1:0] name_cnt_reg, name_cnt_next;
    logic              name_over_reg, name_over_next;
    err_t              first_err_reg, first_err_next;
    label_t            label_reg, label_next;

    logic   is_letter, is_digit, is_dot, is_hyphen;
    err_t   err_lead, err_last, code;
    label_t label_upd;

    always_comb begin
        is_letter = (item.char_code >= 8'h41 && item.char_code <= 8'h5A) ||
                    (item.char_code >= 8'h61 && item.char_code <= 8'h7A);
        is_digit  = item.char_code >= 8'h30 && item.char_code <= 8'h39;
        is_dot    = item.char_code == CH_DOT;
        is_hyphen = item.char_code == CH_HYPHEN;

        // leading character of the whole name must be alphanumeric
        err_lead = first_err_reg;
        if (name_cnt_reg == '0 && !is_letter && !is_digit && first_err_reg == ERR_NONE) begin
            err_lead = ERR_EDGE;
        end
        name_over_next = name_over_reg || (name_cnt_reg >= max_name);
        name_cnt_next  = (name_cnt_reg != '1) ? name_cnt_reg + 1'b1 : name_cnt_reg;

        label_upd      = label_reg;
        first_err_next = err_lead;
        if (is_dot) begin
            if (err_lead == ERR_NONE) begin
                first_err_next = close_code(label_reg, 1'b0);
            end
            label_upd = LABEL_CLR;
        end else begin
            label_upd.over  = label_reg.over || (label_reg.count >= max_label);
            label_upd.count = (label_reg.count != '1) ? label_reg.count + 1'b1
                                                      : label_reg.count;
            if (is_hyphen) begin
                if (label_reg.first) begin
                    label_upd.start_bad = 1'b1;
                end
                label_upd.prev_hyphen = 1'b1;
            end else begin
                label_upd.prev_hyphen = 1'b0;
                if (is_digit) begin
                    label_upd.has_digit = 1'b1;
                end else if (!is_letter) begin
                    label_upd.bad_char = 1'b1;
                end
            end
            label_upd.first = 1'b0;
        end

        // end of name: close the final label, name length error wins
        err_last = (first_err_next == ERR_NONE) ? close_code(label_upd, 1'b1)
                                                : first_err_next;
        code = name_over_next ? ERR_NAME_LEN : err_last;
        result.valid_res  = (code == ERR_NONE);
        result.fault_code = code;

        label_next = label_upd;
        if (item.is_last) begin
            name_cnt_next  = '0;
            name_over_next = 1'b0;
            first_err_next = ERR_NONE;
            label_next     = LABEL_CLR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_cnt_reg  <= '0;
            name_over_reg <= 1'b0;
            first_err_reg <= ERR_NONE;
            label_reg     <= LABEL_CLR;
        end else if (advance) begin
            name_cnt_reg  <= name_cnt_next;
            name_over_reg <= name_over_next;
            first_err_reg <= first_err_next;
            label_reg     <= label_next;
        end
    end
endmodule

// ===== rtl/domain_name_validator_core.sv =====
// Domain name validator, top level: config registers, result register.
// Depends on dnv_pkg, dnv_in_stage, dnv_scan and the macros header.
//
// Usage:
//  - Input channel s_*: one character item per handshake; s_tlast marks the
//    last character of a name. Every item is taken; only the last one of a
//    name produces a result.
//  - Result channel m_*: one item per name, valid flag and error code.
//  - Config port: cfg_we with cfg_index 0 (max name length, 9 bits) or
//    1 (max label length, 7 bits); write only while the block is idle.
// Timing:
//  - Items pass an input register, then the scan logic, then the result
//    register, where m_tvalid rises once the last character is scanned.
//  - The scan is a single combinational step.
//  - One item per cycle, except as held by a pending result (below).
//  - While a result waits on m_tready, non-final characters keep flowing;
//    the next name's last character waits in the input register and
//    s_tready stays low until the result is taken.
// Reset: synchronous, active low; limits return to 255 and 63, scan state
// and the valid flags of both channel registers are cleared.
`include "domain_name_validator_core_macros.svh"

module domain_name_validator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] valid_res, [3:1] fault_code, [7:4] zero
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_wdata
);
    import dnv_pkg::*;

    logic [NAME_W-1:0]  max_name_reg;
    logic [LABEL_W-1:0] max_label_reg;

    item_t   s_item;
    item_t   cur_item;
    logic    cur_valid;
    logic    advance;
    logic    out_free;
    result_t scan_res;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_name_reg  <= NAME_LIMIT_RST;
            max_label_reg <= LABEL_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_NAME:  max_name_reg  <= cfg_wdata[NAME_W-1:0];
                CFG_MAX_LABEL: max_label_reg <= cfg_wdata[LABEL_W-1:0];
                default:       max_name_reg  <= max_name_reg;
            endcase
        end
    end

    assign s_item.char_code = s_tdata;
    assign s_item.is_last   = s_tlast;

    // a non-final character never needs the result slot
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = cur_valid && (!cur_item.is_last || out_free);

    dnv_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (cur_valid),
        .item       (cur_item)
    );

    dnv_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (cur_item),
        .max_name  (max_name_reg),
        .max_label (max_label_reg),
        .result    (scan_res)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && cur_item.is_last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && cur_item.is_last) begin
            m_res_reg <= scan_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_res_reg.fault_code, m_res_reg.valid_res};

    // a pending result is never overwritten by the next name's end
    `DNV_ASSERT(a_no_overwrite, aclk, aresetn,
        (m_valid_reg && !m_tready && cur_valid && cur_item.is_last) |-> !advance)
    // a result appears only after a final character was processed
    `DNV_ASSERT(a_rise_from_last, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(advance && cur_item.is_last))
    // the flag and the code agree
    `DNV_ASSERT(a_flag_matches_code, aclk, aresetn,
        m_valid_reg |-> (m_res_reg.valid_res == (m_res_reg.fault_code == ERR_NONE)))
    // nothing moves through the scan without a held input item
    `DNV_ASSERT_ALWAYS(a_advance_needs_item, aclk, advance |-> cur_valid)
endmodule
